FILE: hdl/hue_histogram_mode_window_macros.svh
// Assertion macros used by the checker file of the hue histogram block.
`ifndef HUE_HISTOGRAM_MODE_WINDOW_MACROS_SVH
`define HUE_HISTOGRAM_MODE_WINDOW_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HHMW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hhmw assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define HHMW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hhmw assertion failed");

`endif

FILE: hdl/hhmw_pkg.sv
// Package: types, codes and constants of the hue histogram mode window block.
`default_nettype none
package hhmw_pkg;

  // Default sizes
  localparam int HUE_BINS_DEF   = 180;
  localparam int COUNT_BITS_DEF = 20;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int HUE_W     = 8;
  localparam int CNT_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLASSIFY   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_BELOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ABOVE = 2'd1;
  localparam logic [CFG_W-1:0]     BELOW_RST = 8'd10;
  localparam logic [CFG_W-1:0]     ABOVE_RST = 8'd20;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [HUE_W-1:0] hue_value;
  } hhmw_in_t;

  typedef struct packed {
    logic             in_window;
    logic [HUE_W-1:0] mode_index;
    logic [CNT_W-1:0] mode_count;
  } hhmw_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the accepted item
    logic rd;     // read the bin of the held hue
    logic upd;    // write back the incremented bin, update the mode
    logic exec;   // classify, clear or no-op on the held item
  } hhmw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic acc_go; // offered item is an accumulate with an in-range hue
  } hhmw_sts_t;

endpackage
`default_nettype wire

FILE: hdl/hhmw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hhmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/hhmw_ctrl.sv
// Controller FSM: sequences accept, bin read and update or exec, result strobe.
`default_nettype none
module hhmw_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire hhmw_pkg::hhmw_sts_t sts_i,
  output hhmw_pkg::hhmw_cmd_t     cmd_o,
  output logic                    busy_o,
  output logic                    done_o
);
  import hhmw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;
  logic       accept;

  assign accept = start_i && (state_q == S_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = sts_i.acc_go ? S_READ : S_EXEC;
        end
      end
      S_READ: state_d = S_UPD;
      S_UPD:  state_d = S_IDLE;
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Result strobe follows the finishing state
  assign done_d = (state_q == S_UPD) || (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.load = accept;
    cmd_o.rd   = (state_q == S_READ);
    cmd_o.upd  = (state_q == S_UPD);
    cmd_o.exec = (state_q == S_EXEC);
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule
`default_nettype wire

FILE: hdl/hhmw_dp.sv
// Datapath: histogram store, valid bits, mode tracking, window compare, registers.
`default_nettype none
module hhmw_dp #(
  parameter int HUE_BINS   = hhmw_pkg::HUE_BINS_DEF,
  parameter int COUNT_BITS = hhmw_pkg::COUNT_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire hhmw_pkg::hhmw_in_t                in_item_i,
  input  wire hhmw_pkg::hhmw_cmd_t               cmd_i,
  output hhmw_pkg::hhmw_sts_t                    sts_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [hhmw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [hhmw_pkg::CFG_W-1:0]        cfg_data_i,
  output hhmw_pkg::hhmw_out_t                    result_o
);
  import hhmw_pkg::*;

  localparam int AW = $clog2(HUE_BINS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Held item
  logic [OP_W-1:0]  op_q;
  logic [HUE_W-1:0] hue_q;
  logic [AW-1:0]    addr;

  // Mode, registers, valid bits
  logic [HUE_W-1:0]      mode_q, mode_d;
  logic [COUNT_BITS-1:0] mcnt_q, mcnt_d;
  logic [CFG_W-1:0]      below_q, below_d;
  logic [CFG_W-1:0]      above_q, above_d;
  logic [HUE_BINS-1:0]   valid_q, valid_d;

  // Bin update path
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] old_cnt;
  logic [COUNT_BITS-1:0] new_cnt;

  // Window compare
  logic signed [HUE_W+1:0] win_lo, win_hi, hue_s;
  logic                    in_win;

  logic [31:0]  cnt_wide;
  hhmw_out_t    res_q, res_d;

  // Status: accumulate with a hue inside the bin range
  assign sts_o.acc_go = (in_item_i.op == OP_ACCUMULATE) &&
                        ({1'b0, in_item_i.hue_value} < (HUE_W+1)'(HUE_BINS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_item_i.op;
      hue_q <= in_item_i.hue_value;
    end
  end

  assign addr = hue_q[AW-1:0];

  hhmw_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (HUE_BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.upd),
    .waddr_i (addr),
    .wdata_i (new_cnt),
    .re_i    (cmd_i.rd),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // Unwritten bins since reset or clear read as zero; count saturates
  assign old_cnt = valid_q[addr] ? rdata : '0;
  assign new_cnt = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + 1'b1;

  // Inclusive window around the mode, signed, no wrap
  assign hue_s  = $signed({2'b00, hue_q});
  assign win_lo = $signed({2'b00, mode_q}) - $signed({2'b00, below_q});
  assign win_hi = $signed({2'b00, mode_q}) + $signed({2'b00, above_q});
  assign in_win = (hue_s >= win_lo) && (hue_s <= win_hi);

  // Mode, valid bits and result
  always_comb begin
    mode_d  = mode_q;
    mcnt_d  = mcnt_q;
    valid_d = valid_q;
    res_d   = res_q;
    if (cmd_i.upd) begin
      valid_d[addr] = 1'b1;
      if (hue_q == mode_q) begin
        mcnt_d = new_cnt;
      end else if (new_cnt > mcnt_q) begin
        mode_d = hue_q;
        mcnt_d = new_cnt;
      end
    end else if (cmd_i.exec && (op_q == OP_CLEAR)) begin
      valid_d = '0;
      mode_d  = '0;
      mcnt_d  = '0;
    end
    cnt_wide = 32'(mcnt_d);
    if (cmd_i.upd || cmd_i.exec) begin
      res_d.in_window  = cmd_i.exec && (op_q == OP_CLASSIFY) && in_win;
      res_d.mode_index = mode_d;
      res_d.mode_count = cnt_wide[CNT_W-1:0];
    end
  end

  // Configuration decode
  always_comb begin
    below_d = below_q;
    above_d = above_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BELOW: below_d = cfg_data_i;
        REG_ABOVE: above_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      mcnt_q  <= '0;
      valid_q <= '0;
      below_q <= BELOW_RST;
      above_q <= ABOVE_RST;
    end else begin
      mode_q  <= mode_d;
      mcnt_q  <= mcnt_d;
      valid_q <= valid_d;
      below_q <= below_d;
      above_q <= above_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o = res_q;

endmodule
`default_nettype wire

FILE: hdl/hue_histogram_mode_window.sv
// Top level of the hue histogram mode window block.
//
//   channel   handshake             payload
//   input     start_i / busy_o      in_item_i  (op, hue_value)
//   result    done_o (strobe)       result_o   (in_window, mode_index, mode_count)
//   config    cfg_we_i              cfg_idx_i, cfg_data_i
//
// An accumulate item with a hue inside the bin range passes READ and UPD before
// the next accept, any other item only EXEC: the bin read-modify-write goes
// through the single registered-read port of the RAM.
// The result is shown for one cycle; UPD registers it for such an accumulate, EXEC
// otherwise; busy_o is low in that cycle, so the next item can be taken there.
// Reset clears the per-bin valid bits at once; no clearing pass is needed, and the
// clear op drops them all at once. The receiver cannot stall the result.
`default_nettype none
module hue_histogram_mode_window #(
  parameter int HUE_BINS   = hhmw_pkg::HUE_BINS_DEF,
  parameter int COUNT_BITS = hhmw_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire hhmw_pkg::hhmw_in_t             in_item_i,
  output logic                                busy_o,
  output logic                                done_o,
  output hhmw_pkg::hhmw_out_t                 result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [hhmw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [hhmw_pkg::CFG_W-1:0]     cfg_data_i
);
  import hhmw_pkg::*;

  hhmw_cmd_t cmd;
  hhmw_sts_t sts;

  hhmw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  hhmw_dp #(
    .HUE_BINS   (HUE_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result_o)
  );

endmodule
`default_nettype wire

FILE: hdl/hhmw_checker.sv
// Port-level checker for the hue histogram block, bound to the top level.
`default_nettype none
`include "hue_histogram_mode_window_macros.svh"
module hhmw_checker #(
  parameter int HUE_BINS = hhmw_pkg::HUE_BINS_DEF
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start_i,
  input wire logic                busy_i,
  input wire logic                done_i,
  input wire hhmw_pkg::hhmw_out_t result_i
);
  import hhmw_pkg::*;

  // An accepted item keeps the block busy in the next cycle
  `HHMW_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_i, busy_i)
  // The block is free again in the cycle its result is shown
  `HHMW_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_i, !busy_i)
  // One result per item: strobes never come back to back
  `HHMW_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_i, !done_i)
  // The reported mode is always a real bin
  `HHMW_ASSERT_IMP(a_mode_range, clk_i, rst_ni, done_i,
                   {1'b0, result_i.mode_index} < (HUE_W+1)'(HUE_BINS))

endmodule

bind hue_histogram_mode_window hhmw_checker #(
  .HUE_BINS (HUE_BINS)
) u_hhmw_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_i   (busy_o),
  .done_i   (done_o),
  .result_i (result_o)
);
`default_nettype wire
